// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_pkg - shared types and constants for the sorted priority queue
// Action codes, store sizing and the control structs that feed the cells.
// ---------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	localparam logic [1:0] ACT_PRIO  = 2'd0;
	localparam logic [1:0] ACT_FRONT = 2'd1;
	localparam logic [1:0] ACT_BACK  = 2'd2;
	localparam logic [1:0] ACT_POP   = 2'd3;

	// broadcast to every cell
	typedef struct packed {
		logic load;   // insert of some kind, store not full
		logic pop;    // pop from a non-empty store
		logic scan;   // priority insert that goes before the first smaller entry
		logic front;  // push at front
	} spq_op_t;

	// per-cell position relative to the fill level
	typedef struct packed {
		logic at_end;   // cell index == occupancy
		logic is_back;  // cell index == occupancy - 1
		logic first;    // cell index == 0
	} spq_pos_t;

endpackage

// ===== hdl/spq_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_cell - one slot of the queue
// Holds one word, marks itself as an insert point and shifts toward the back
// on insert or toward the front on pop, taking its neighbor's word.
// ---------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic                     clk,
	input  spq_op_t                  op,
	input  spq_pos_t                 pos,
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [DATA_W-1:0] prev_entry,
	input  logic signed [DATA_W-1:0] next_entry,
	input  logic                     seen_in,
	output logic                     seen_out,
	output logic                     back_ge,
	output logic signed [DATA_W-1:0] entry
);

	logic signed [DATA_W-1:0] entry_q;
	logic                     less;
	logic                     mark;

	assign less     = entry_q < value;
	assign back_ge  = pos.is_back & ~less;
	assign mark     = pos.at_end | (op.front & pos.first) | (op.scan & less);
	assign seen_out = seen_in | mark;
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		if (op.pop) begin
			entry_q <= next_entry;
		end else if (op.load) begin
			if (seen_in) begin
				entry_q <= prev_entry;
			end else if (mark) begin
				entry_q <= value;
			end
		end
	end

endmodule

// ===== hdl/sorted_priority_queue_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_priority_queue_core - bounded ordered queue of signed words
// A row of cells, front at cell 0. Insert point is found by a mark chain
// running front to back; the word there and all behind it move one back.
// ---------------------------------------------------------------------------
//  channel   handshake          fields
//  command   start / busy       action, new_value
//  result    done (1 cycle)     popped_value, pop_valid, rejected, entry_count
//
//  One word per cycle: busy stays low, a command is taken at every edge
//  with start high. Its result shows on the next cycle for one cycle.
//  The insert-point chain through all DEPTH cells sets the clock period.
//  Reset clears the fill count and the result strobe; cell contents stay
//  undefined until written. The receiver cannot stall the result.
// ---------------------------------------------------------------------------
module sorted_priority_queue_core
	import spq_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                action,
	input  logic signed [DATA_W-1:0]  new_value,
	output logic                      done,
	output logic signed [DATA_W-1:0]  popped_value,
	output logic                      pop_valid,
	output logic                      rejected,
	output logic [COUNT_W-1:0]        entry_count
);

	logic [CNT_W-1:0]         count_q;
	logic                     done_q;
	logic signed [DATA_W-1:0] popped_q;
	logic                     pop_valid_q;
	logic                     rejected_q;

	spq_op_t                  op;
	logic                     full;
	logic                     empty;
	logic                     is_pop;
	logic                     any_back_ge;
	logic                     front_less;
	logic signed [DATA_W-1:0] entry_w [DEPTH];
	logic                     back_ge_w [DEPTH];
	logic                     seen_w [DEPTH+1];

	assign busy   = 1'b0;
	assign full   = count_q == CNT_W'(DEPTH);
	assign empty  = count_q == '0;
	assign is_pop = action == ACT_POP;

	// a front word smaller than the new one wins over the back check
	assign front_less = entry_w[0] < new_value;

	always_comb begin
		any_back_ge = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			any_back_ge = any_back_ge | back_ge_w[i];
		end
	end

	always_comb begin
		op.pop   = start & is_pop & ~empty;
		op.load  = start & ~is_pop & ~full;
		op.scan  = (action == ACT_PRIO) & (~any_back_ge | front_less);
		op.front = action == ACT_FRONT;
	end

	assign seen_w[0] = 1'b0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		spq_pos_t                 pos;
		logic signed [DATA_W-1:0] prev_d;
		logic signed [DATA_W-1:0] next_d;

		assign pos.at_end  = count_q == CNT_W'(g);
		assign pos.is_back = count_q == CNT_W'(g + 1);
		assign pos.first   = g == 0;
		assign prev_d      = (g == 0) ? new_value : entry_w[(g == 0) ? 0 : g - 1];
		assign next_d      = (g == DEPTH - 1) ? entry_w[g]
		                                      : entry_w[(g == DEPTH - 1) ? g : g + 1];

		spq_cell u_cell (
			.clk        (clk),
			.op         (op),
			.pos        (pos),
			.value      (new_value),
			.prev_entry (prev_d),
			.next_entry (next_d),
			.seen_in    (seen_w[g]),
			.seen_out   (seen_w[g+1]),
			.back_ge    (back_ge_w[g]),
			.entry      (entry_w[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			done_q      <= 1'b0;
			pop_valid_q <= 1'b0;
			rejected_q  <= 1'b0;
		end else begin
			done_q      <= start;
			pop_valid_q <= op.pop;
			rejected_q  <= start & ~is_pop & full;
			if (op.pop) begin
				count_q <= count_q - CNT_W'(1);
			end else if (op.load) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		popped_q <= op.pop ? entry_w[0] : '0;
	end

	assign done         = done_q;
	assign popped_value = popped_q;
	assign pop_valid    = pop_valid_q;
	assign rejected     = rejected_q;
	assign entry_count  = COUNT_W'(count_q);

	// every command gets exactly one result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> done_q)
		else $error("command without result strobe");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |=> !done_q)
		else $error("result strobe without command");

	// a rejected insert only happens at full occupancy and leaves it there
	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		rejected_q |-> (count_q == CNT_W'(DEPTH)) && $stable(count_q))
		else $error("reject while not full");

	// a successful pop drops the fill count by one
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid_q |-> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not shrink occupancy");

	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop_valid_q && rejected_q))
		else $error("pop and reject in one result");

endmodule
